@@ design/rgb_to_ycbcr420_converter_unit_macros.svh @@
// Assertion helpers shared by the checker of the colour converter.
`ifndef RGB_TO_YCBCR420_CONVERTER_UNIT_MACROS_SVH
`define RGB_TO_YCBCR420_CONVERTER_UNIT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define RYCC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property that must also hold while reset is asserted.
`define RYCC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

@@ design/rycc_pkg.sv @@
package rycc_pkg;

    localparam int PIX_W  = 8;
    localparam int PAIR_W = 9;
    localparam int SUM_W  = 10;
    localparam int HALF_W = 12;

    localparam logic [HALF_W-1:0] HALF_WIDTH_RESET  = 12'd320;
    localparam logic [HALF_W-1:0] HALF_HEIGHT_RESET = 12'd240;

    typedef enum logic {
        REG_HALF_WIDTH  = 1'b0,
        REG_HALF_HEIGHT = 1'b1
    } reg_index_t;

    // Luma, Q16
    localparam logic [15:0] Y_R     = 16'd19595;
    localparam logic [15:0] Y_G     = 16'd38470;
    localparam logic [15:0] Y_B     = 16'd7471;
    localparam logic [23:0] Y_ROUND = 24'd32768;

    // Chroma magnitudes, Q16 on 4-pixel sums; the 0.5 weights are shifts
    localparam logic [14:0] CB_R = 15'd11058;
    localparam logic [14:0] CB_G = 15'd21710;
    localparam logic [14:0] CR_G = 15'd27439;
    localparam logic [14:0] CR_B = 15'd5329;
    localparam int          HALF_SHIFT = 15;
    // (128 + 0.5) << 18
    localparam logic [26:0] C_OFFSET = 27'd33685504;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             chroma_valid;
        logic [SUM_W-1:0] red_sum;
        logic [SUM_W-1:0] green_sum;
        logic [SUM_W-1:0] blue_sum;
        logic             frame_end;
    } item_t;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic             chroma_valid;
        logic [PIX_W-1:0] blue_difference;
        logic [PIX_W-1:0] red_difference;
        logic             frame_end;
    } result_t;

endpackage

@@ design/rycc_queue.sv @@
module rycc_queue #(
    parameter type word_t = logic,
    parameter int  DEPTH  = 2,
    localparam int CNT_W  = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  word_t            push_word,
    output logic             full,
    input  logic             pop,
    output word_t            head_word,
    output logic             empty,
    output logic [CNT_W-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    word_t            slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign count     = count_reg;
    assign head_word = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

@@ design/rycc_front.sv @@
module rycc_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [rycc_pkg::PIX_W-1:0]    red,
    input  logic [rycc_pkg::PIX_W-1:0]    green,
    input  logic [rycc_pkg::PIX_W-1:0]    blue,
    input  logic [rycc_pkg::HALF_W-1:0]   half_width,
    input  logic [rycc_pkg::HALF_W-1:0]   half_height,
    output logic                          q_push,
    output rycc_pkg::item_t               q_word,
    input  logic                          q_full
);

    localparam int CW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int ROW_PAIRS  = MAX_HEIGHT / 2;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int MW         = (CW > RW) ? CW : RW;
    localparam int CMPW       = ((MW > rycc_pkg::HALF_W) ? MW : rycc_pkg::HALF_W) + 1;
    localparam int PW         = rycc_pkg::PAIR_W;
    localparam int ENTRY_W    = 3 * PW;

    logic [CW-1:0]      col_reg;
    logic [RW-1:0]      row_reg;
    logic [23:0]        left_reg;

    // line store: one set of pair sums per block, undefined until written
    logic [ENTRY_W-1:0] line_mem [LINE_DEPTH];
    logic [ENTRY_W-1:0] line_rd_reg;

    logic               fs_valid_reg;
    logic [7:0]         fs_red_reg;
    logic [7:0]         fs_green_reg;
    logic [7:0]         fs_blue_reg;
    logic               fs_chroma_reg;
    logic [PW-1:0]      fs_pr_reg;
    logic [PW-1:0]      fs_pg_reg;
    logic [PW-1:0]      fs_pb_reg;
    logic               fs_fend_reg;

    logic [CMPW-1:0]    hw_ext;
    logic [CMPW-1:0]    hh_ext;
    logic [CMPW-1:0]    hw_eff;
    logic [CMPW-1:0]    hh_eff;
    logic [CMPW-1:0]    last_col_wide;
    logic [CMPW-1:0]    last_row_wide;
    logic [CW-1:0]      last_col;
    logic [RW-1:0]      last_row;
    logic               col_wrap;
    logic               row_wrap;
    logic               accept;
    logic               x_odd;
    logic               y_odd;
    logic [AW-1:0]      slot;
    logic [PW-1:0]      pr;
    logic [PW-1:0]      pg;
    logic [PW-1:0]      pb;
    logic [CW-1:0]      col_next;
    logic [RW-1:0]      row_next;

    // half sizes: zero acts as one, too large acts as the bound
    always_comb
    begin
        hw_ext = CMPW'(half_width);
        hh_ext = CMPW'(half_height);
        if (hw_ext == '0)
        begin
            hw_eff = CMPW'(1);
        end
        else if (hw_ext > CMPW'(LINE_DEPTH))
        begin
            hw_eff = CMPW'(LINE_DEPTH);
        end
        else
        begin
            hw_eff = hw_ext;
        end
        if (hh_ext == '0)
        begin
            hh_eff = CMPW'(1);
        end
        else if (hh_ext > CMPW'(ROW_PAIRS))
        begin
            hh_eff = CMPW'(ROW_PAIRS);
        end
        else
        begin
            hh_eff = hh_ext;
        end
        last_col_wide = (hw_eff << 1) - CMPW'(1);
        last_row_wide = (hh_eff << 1) - CMPW'(1);
    end

    assign last_col = last_col_wide[CW-1:0];
    assign last_row = last_row_wide[RW-1:0];
    assign col_wrap = (col_reg >= last_col);
    assign row_wrap = (row_reg >= last_row);

    assign full   = fs_valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = fs_valid_reg && !q_full;

    assign x_odd = col_reg[0];
    assign y_odd = row_reg[0];
    assign slot  = AW'(col_reg >> 1);
    assign pr    = {1'b0, left_reg[23:16]} + {1'b0, red};
    assign pg    = {1'b0, left_reg[15:8]} + {1'b0, green};
    assign pb    = {1'b0, left_reg[7:0]} + {1'b0, blue};

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_wrap)
        begin
            col_next = '0;
            row_next = row_wrap ? '0 : row_reg + 1'b1;
        end
        else
        begin
            col_next = col_reg + 1'b1;
            if (row_wrap && (row_reg > last_row))
            begin
                row_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            left_reg     <= '0;
            fs_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                if (!x_odd)
                begin
                    left_reg <= {red, green, blue};
                end
                fs_valid_reg <= 1'b1;
            end
            else if (q_push)
            begin
                fs_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fs_red_reg    <= red;
            fs_green_reg  <= green;
            fs_blue_reg   <= blue;
            fs_chroma_reg <= x_odd && y_odd;
            fs_pr_reg     <= pr;
            fs_pg_reg     <= pg;
            fs_pb_reg     <= pb;
            fs_fend_reg   <= col_wrap && row_wrap;
        end
    end

    // even row stores its pair sums, odd row reads them back
    always_ff @(posedge clk)
    begin
        if (accept && x_odd)
        begin
            if (!y_odd)
            begin
                line_mem[slot] <= {pr, pg, pb};
            end
            else
            begin
                line_rd_reg <= line_mem[slot];
            end
        end
    end

    always_comb
    begin
        q_word.red          = fs_red_reg;
        q_word.green        = fs_green_reg;
        q_word.blue         = fs_blue_reg;
        q_word.chroma_valid = fs_chroma_reg;
        q_word.red_sum      = {1'b0, fs_pr_reg} + {1'b0, line_rd_reg[3*PW-1:2*PW]};
        q_word.green_sum    = {1'b0, fs_pg_reg} + {1'b0, line_rd_reg[2*PW-1:PW]};
        q_word.blue_sum     = {1'b0, fs_pb_reg} + {1'b0, line_rd_reg[PW-1:0]};
        q_word.frame_end    = fs_fend_reg;
    end

endmodule

@@ design/rycc_back.sv @@
module rycc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rycc_pkg::item_t   in_word,
    input  logic              in_empty,
    output logic              in_pop,
    input  logic              out_pop,
    output rycc_pkg::result_t out_word,
    output logic              out_empty
);

    localparam int ODEPTH = 4;
    localparam int OCW    = $clog2(ODEPTH + 1);
    localparam int LW     = OCW + 1;

    logic             b1_valid_reg;
    logic [23:0]      b1_yr_reg;
    logic [23:0]      b1_yg_reg;
    logic [23:0]      b1_yb_reg;
    logic [24:0]      b1_cbr_reg;
    logic [24:0]      b1_cbg_reg;
    logic [24:0]      b1_crg_reg;
    logic [24:0]      b1_crb_reg;
    logic [9:0]       b1_rs_reg;
    logic [9:0]       b1_bs_reg;
    logic             b1_chroma_reg;
    logic             b1_fend_reg;

    logic             b2_valid_reg;
    rycc_pkg::result_t b2_word_reg;
    rycc_pkg::result_t b2_word_next;

    logic [23:0]      y_acc;
    logic [26:0]      cb_acc;
    logic [26:0]      cr_acc;
    logic [OCW-1:0]   ocount;
    logic             ofull;
    logic             out_fire;
    logic [LW-1:0]    load;
    logic [LW-1:0]    room;

    function automatic logic [7:0] sat_byte(input logic [26:0] acc);
        return acc[26] ? 8'hFF : acc[25:18];
    endfunction

    // words in flight plus the new one must fit in the output queue
    assign out_fire = out_pop && !out_empty;
    assign load     = LW'(ocount) + LW'(b1_valid_reg) + LW'(b2_valid_reg);
    assign room     = LW'(ODEPTH) + LW'(out_fire);
    assign in_pop   = !in_empty && (load < room);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= in_pop;
            b2_valid_reg <= b1_valid_reg;
        end
    end

    // stage 1: products
    always_ff @(posedge clk)
    begin
        if (in_pop)
        begin
            b1_yr_reg     <= 24'(rycc_pkg::Y_R) * 24'(in_word.red);
            b1_yg_reg     <= 24'(rycc_pkg::Y_G) * 24'(in_word.green);
            b1_yb_reg     <= 24'(rycc_pkg::Y_B) * 24'(in_word.blue);
            b1_cbr_reg    <= 25'(rycc_pkg::CB_R) * 25'(in_word.red_sum);
            b1_cbg_reg    <= 25'(rycc_pkg::CB_G) * 25'(in_word.green_sum);
            b1_crg_reg    <= 25'(rycc_pkg::CR_G) * 25'(in_word.green_sum);
            b1_crb_reg    <= 25'(rycc_pkg::CR_B) * 25'(in_word.blue_sum);
            b1_rs_reg     <= in_word.red_sum;
            b1_bs_reg     <= in_word.blue_sum;
            b1_chroma_reg <= in_word.chroma_valid;
            b1_fend_reg   <= in_word.frame_end;
        end
    end

    // stage 2: sums, rounding and clamping; chroma sums never go negative
    always_comb
    begin
        y_acc  = b1_yr_reg + b1_yg_reg + b1_yb_reg + rycc_pkg::Y_ROUND;
        cb_acc = rycc_pkg::C_OFFSET + (27'(b1_bs_reg) << rycc_pkg::HALF_SHIFT)
                 - 27'(b1_cbr_reg) - 27'(b1_cbg_reg);
        cr_acc = rycc_pkg::C_OFFSET + (27'(b1_rs_reg) << rycc_pkg::HALF_SHIFT)
                 - 27'(b1_crg_reg) - 27'(b1_crb_reg);
        b2_word_next.luma            = y_acc[23:16];
        b2_word_next.chroma_valid    = b1_chroma_reg;
        b2_word_next.blue_difference = b1_chroma_reg ? sat_byte(cb_acc) : 8'd0;
        b2_word_next.red_difference  = b1_chroma_reg ? sat_byte(cr_acc) : 8'd0;
        b2_word_next.frame_end       = b1_fend_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b1_valid_reg)
        begin
            b2_word_reg <= b2_word_next;
        end
    end

    rycc_queue #(
        .word_t (rycc_pkg::result_t),
        .DEPTH  (ODEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (b2_valid_reg),
        .push_word (b2_word_reg),
        .full      (ofull),
        .pop       (out_pop),
        .head_word (out_word),
        .empty     (out_empty),
        .count     (ocount)
    );

    // the credit check keeps the output queue from overflowing
    logic unused_ofull;
    assign unused_ofull = ofull;

endmodule

@@ design/rgb_to_ycbcr420_converter_unit.sv @@
// Path: an accepted pixel word passes the front register, mid queue, product stage,
// sum/clamp stage and result queue before its result word reaches the head of that queue.
// Throughput: one pixel word per cycle while full stays low and results are popped;
// the two-stage arithmetic pipe is decoupled by a 2-deep and a 4-deep queue.
// Reset (rst_n low, asynchronous): counters, queues and left pixel clear, half sizes
// return to 320 x 240; the line store is not cleared and needs no start-up pass.
module rgb_to_ycbcr420_converter_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        clk,
    input  logic        rst_n,

    // pixel side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,

    // result side
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  luma,
    output logic        chroma_valid,
    output logic [7:0]  blue_difference,
    output logic [7:0]  red_difference,
    output logic        frame_end,

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [rycc_pkg::HALF_W-1:0] half_width_reg;
    logic [rycc_pkg::HALF_W-1:0] half_height_reg;
    rycc_pkg::reg_index_t        reg_index;
    logic                        cfg_write;

    rycc_pkg::item_t             mid_push_word;
    rycc_pkg::item_t             mid_head_word;
    logic                        mid_push;
    logic                        mid_full;
    logic                        mid_empty;
    logic                        mid_pop;
    logic [1:0]                  mid_count;
    rycc_pkg::result_t           head_word;

    // ------------------------------------------------------------------
    // Configuration registers. Registers sit at byte addresses 0 and 4, so
    // only address bit 2 selects; the low bits are ignored. Writes land in the
    // access phase; pready is tied high, so there are no wait states.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_index = rycc_pkg::reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    logic [1:0] unused_paddr;
    assign unused_paddr = paddr[1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg  <= rycc_pkg::HALF_WIDTH_RESET;
            half_height_reg <= rycc_pkg::HALF_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                rycc_pkg::REG_HALF_WIDTH:  half_width_reg  <= pwdata[rycc_pkg::HALF_W-1:0];
                rycc_pkg::REG_HALF_HEIGHT: half_height_reg <= pwdata[rycc_pkg::HALF_W-1:0];
                default:                   half_width_reg  <= half_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            rycc_pkg::REG_HALF_WIDTH:  prdata = {20'd0, half_width_reg};
            rycc_pkg::REG_HALF_HEIGHT: prdata = {20'd0, half_height_reg};
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Front: tracks the raster position, forms horizontal pair sums, keeps
    // the even-row pair sums in the line store and, on the bottom-right
    // pixel of a 2x2 block, adds the stored pair to give 4-pixel sums.
    // The word it holds waits in its own register when the queue is full,
    // so full reflects only queue back-pressure, not pipeline occupancy.
    // ------------------------------------------------------------------
    rycc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .half_width  (half_width_reg),
        .half_height (half_height_reg),
        .q_push      (mid_push),
        .q_word      (mid_push_word),
        .q_full      (mid_full)
    );

    // Short queue between classification and arithmetic.
    rycc_queue #(
        .word_t (rycc_pkg::item_t),
        .DEPTH  (2)
    ) u_mid_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mid_push),
        .push_word (mid_push_word),
        .full      (mid_full),
        .pop       (mid_pop),
        .head_word (mid_head_word),
        .empty     (mid_empty),
        .count     (mid_count)
    );

    logic [1:0] unused_mid_count;
    assign unused_mid_count = mid_count;

    // ------------------------------------------------------------------
    // Back: Q16 luma and Q18 chroma products, rounding, clamping, then the
    // result queue. It only draws a word when the result queue is sure to
    // have room once that word reaches it, so the pipe itself never stalls.
    // ------------------------------------------------------------------
    rycc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (mid_head_word),
        .in_empty  (mid_empty),
        .in_pop    (mid_pop),
        .out_pop   (pop),
        .out_word  (head_word),
        .out_empty (empty)
    );

    assign luma            = head_word.luma;
    assign chroma_valid    = head_word.chroma_valid;
    assign blue_difference = head_word.blue_difference;
    assign red_difference  = head_word.red_difference;
    assign frame_end       = head_word.frame_end;

endmodule

@@ design/rycc_checker.sv @@
`include "rgb_to_ycbcr420_converter_unit_macros.svh"

module rycc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       pop,
    input logic       empty,
    input logic [7:0] luma,
    input logic       chroma_valid,
    input logic [7:0] blue_difference,
    input logic [7:0] red_difference,
    input logic       frame_end
);

    // without a completed block the chroma fields read zero
    `RYCC_ASSERT(a_chroma_zero, clk, rst_n, (!empty && !chroma_valid) |-> (blue_difference == 8'd0 && red_difference == 8'd0), "chroma set without a completed block")

    // a waiting word holds until taken
    `RYCC_ASSERT(a_head_holds, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(luma) && $stable(chroma_valid) && $stable(blue_difference) && $stable(red_difference) && $stable(frame_end)), "result word changed while waiting")

    // a reset held over an edge leaves the result queue empty
    `RYCC_ASSERT_ALWAYS(a_empty_in_reset, clk, !rst_n |=> (rst_n || empty), "result queue not empty in reset")

endmodule

bind rgb_to_ycbcr420_converter_unit rycc_checker u_rycc_checker (.*);
